// ----- rtl/sorted_priority_queue_assert.svh -----
// assertion macros used by the sorted_priority_queue rtl
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// clocked check, disabled while reset is held
`define SPQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int VAL_W         = 32;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REM_MIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REM_MAX = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    rem_min;
        logic                    rem_max;
        logic signed [VAL_W-1:0] val;
    } spq_cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic signed [VAL_W-1:0] value;
    } spq_link_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// sorted priority queue: insert, remove smallest, remove largest
// result: registered, valid the cycle after the request transaction
// throughput: one request per cycle while the result is taken; every cell shifts in the same cycle
// the output register frees the input when its result is taken
// reset: synchronous active-low, empties the queue and drops any pending result
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spq_pkg::VAL_W-1:0]     s_tdata,   // [31:0] value_in
    input  logic [spq_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value_out from bit 0, then fill_count, zero padded to bytes
    output logic [((spq_pkg::VAL_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [spq_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((VAL_W + CNT_W + 7) / 8) * 8;

    // request transaction and decode
    logic             req_fire;
    logic             is_ins, is_min, is_max;
    logic             full, empty;
    spq_cmd_t         cmd;

    // fill level, mirrors the occupied cells
    logic [CNT_W-1:0] count_reg, count_next;

    // output register
    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] m_value_reg, m_value_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [CNT_W-1:0]        m_fill_reg;

    // cell chain wiring
    spq_link_t               links [DEPTH];
    logic [VAL_W-1:0]        tails [DEPTH];
    logic [VAL_W-1:0]        tail_or;
    logic [DEPTH-1:0]        occupied;

    // new request allowed once the pending result leaves
    assign s_tready = !m_valid_reg || m_tready;
    assign req_fire = s_tvalid && s_tready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign is_ins = (s_tuser == REQ_INSERT);
    assign is_min = (s_tuser == REQ_REM_MIN);
    assign is_max = (s_tuser == REQ_REM_MAX);

    // overflow and underflow never reach the cells
    assign cmd.ins     = req_fire && is_ins && !full;
    assign cmd.rem_min = req_fire && is_min && !empty;
    assign cmd.rem_max = req_fire && is_max && !empty;
    assign cmd.val     = $signed(s_tdata);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            spq_link_t left_l, right_l;
            if (g == 0) begin : g_head
                // head sees an always-occupied, never-greater neighbor
                assign left_l.valid = 1'b1;
                assign left_l.gt    = 1'b0;
                assign left_l.value = '0;
            end else begin : g_mid_l
                assign left_l = links[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_l.valid = 1'b0;
                assign right_l.gt    = 1'b0;
                assign right_l.value = '0;
            end else begin : g_mid_r
                assign right_l = links[g+1];
            end
            spq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .left_link  (left_l),
                .right_link (right_l),
                .link       (links[g]),
                .tail_value (tails[g])
            );
            assign occupied[g] = links[g].valid;
        end
    endgenerate

    // largest value: only the last occupied cell is nonzero
    always_comb begin
        tail_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_or = tail_or | tails[i];
        end
    end

    // result of the accepted request
    always_comb begin
        count_next    = count_reg;
        m_value_next  = '0;
        m_status_next = STATUS_OK;
        if (is_ins) begin
            if (full) begin
                m_status_next = STATUS_OVERFLOW;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (is_min || is_max) begin
            if (empty) begin
                m_status_next = STATUS_UNDERFLOW;
            end else begin
                count_next   = count_reg - CNT_W'(1);
                m_value_next = is_min ? links[0].value : $signed(tail_or);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (req_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload captured with each request transaction
    always_ff @(posedge aclk) begin
        if (req_fire) begin
            m_value_reg  <= m_value_next;
            m_status_reg <= m_status_next;
            m_fill_reg   <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_fill_reg, m_value_reg});
    assign m_tuser  = m_status_reg;

    // fill level agrees with the occupied cells
    `SPQ_ASSERT(a_count_match, aclk, aresetn, $countones(occupied) == int'(count_reg), "count differs from occupied cells")
    // occupied cells form a contiguous run from the head
    `SPQ_ASSERT(a_contiguous, aclk, aresetn, ((occupied >> 1) & ~occupied) == '0, "gap in occupied cells")
    // underflow and overflow never carry a value
    `SPQ_ASSERT(a_err_zero, aclk, aresetn, (m_valid_reg && m_status_reg != STATUS_OK) |-> (m_value_reg == '0), "error result carries a value")
    // fill level never goes past the depth
    `SPQ_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "count above depth")
    // a reset cycle leaves the queue empty with no pending result
    `SPQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (count_reg == '0 && !m_valid_reg), "not idle after reset")

endmodule

// ----- rtl/spq_cell.sv -----
// one storage cell of the sorted chain
module spq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_pkg::spq_cmd_t  cmd,
    input  spq_pkg::spq_link_t left_link,
    input  spq_pkg::spq_link_t right_link,
    output spq_pkg::spq_link_t link,
    output logic [spq_pkg::VAL_W-1:0] tail_value
);
    import spq_pkg::*;

    logic                    valid_reg, valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    gt;

    // stored value strictly greater than the new one moves right
    assign gt = valid_reg && (value_reg > cmd.val);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.ins) begin
            if (left_link.gt) begin
                value_next = left_link.value;
                valid_next = 1'b1;
            end else if (gt || (!valid_reg && left_link.valid)) begin
                value_next = cmd.val;
                valid_next = 1'b1;
            end
        end else if (cmd.rem_min) begin
            value_next = right_link.value;
            valid_next = right_link.valid;
        end else if (cmd.rem_max) begin
            valid_next = valid_reg && right_link.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

    // only the last occupied cell drives its value toward the tail bus
    assign tail_value = (valid_reg && !right_link.valid) ? value_reg : '0;

endmodule
